[hw/rtl/gps_pkg.sv]
package gps_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_DEGREE_DEF   = 8;
  localparam int LABEL_BITS_DEF   = 32;
  localparam int MAX_RESULTS      = 16;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int OLABEL_W = 32;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_VERTEX = 2'd0,
    CMD_ADD_EDGE   = 2'd1,
    CMD_FIND       = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_NO_PATH  = 3'd1,
    STAT_UNKNOWN  = 3'd2,
    STAT_VTX_FULL = 3'd3,
    STAT_ADJ_FULL = 3'd4
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_BFS   = 2'd0,
    MODE_STACK = 2'd1,
    MODE_REC   = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOOK_RD,
    S_LOOK_CMP,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_EDGE_FIN,
    S_WL_POP,
    S_WL_CUR,
    S_NB_RD,
    S_NB_CHK,
    S_REC_STEP,
    S_REC_CHK,
    S_TRACE,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_RESP
  } state_e;

endpackage

[hw/rtl/gps_cmd_if.sv]
interface gps_cmd_if import gps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key_a;
  logic [KEY_W-1:0] key_b;

  modport source (output valid, cmd, key_a, key_b, input ready);
  modport sink (input valid, cmd, key_a, key_b, output ready);
endinterface

[hw/rtl/gps_res_if.sv]
interface gps_res_if import gps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OLABEL_W-1:0] vertex_label;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, vertex_label, status, last, input ready);
  modport sink (input valid, vertex_label, status, last, output ready);
endinterface

[hw/rtl/gps_cfg_if.sv]
interface gps_cfg_if import gps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/graph_path_search.sv]
// Add vertex writes the label and the self-loop, then responds. Add edge scans the stored
// labels, reads the source adjacency entries, then writes the edge and responds. Find scans
// the labels, then pops the work list, expands each vertex and reads its adjacency entries
// (recursive mode: tries entries and steps back), collects the path and emits one path label
// per result. One command at a time; the next is taken once its last result is registered.
// Reset clears the counts, marks, mode and output; the label and list memories are not cleared.
module graph_path_search import gps_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
  parameter int LABEL_BITS   = LABEL_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gps_cmd_if.sink   cmd_s,
  gps_res_if.source res_m,
  gps_cfg_if.sink   cfg_s
);

  localparam int MV   = MAX_VERTICES;
  localparam int MD   = MAX_DEGREE;
  localparam int LB   = LABEL_BITS;
  localparam int VI   = $clog2(MV);
  localparam int VCW  = $clog2(MV + 1);
  localparam int DI   = $clog2(MD);
  localparam int CW   = $clog2(MD + 1);
  localparam int NLD  = MV * (1 << DI);
  localparam int WLD  = MV * MD + 1;
  localparam int WLI  = $clog2(WLD);
  localparam int WLP  = $clog2(WLD + 1);

  state_e state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [VCW-1:0] vcount_q, vcount_d;
  logic [CW-1:0]  ncount_q [MV];
  logic [CW-1:0]  ncount_d [MV];
  logic [MV-1:0]  visited_q, visited_d;
  logic [MV-1:0]  pred_v_q, pred_v_d;
  logic [VI-1:0]  pred_q [MV];
  logic [VI-1:0]  pred_d [MV];
  logic [VI-1:0]  pb_q [MV];
  logic [VI-1:0]  pb_d [MV];
  logic [CW-1:0]  pos_q [MV];
  logic [CW-1:0]  pos_d [MV];
  cmd_e           cmd_q, cmd_d;
  logic [LB-1:0]  ka_q, ka_d, kb_q, kb_d;
  logic [VCW-1:0] idx_q, idx_d;
  logic [VI-1:0]  a_q, a_d, b_q, b_d, cur_q, cur_d;
  logic           a_fnd_q, a_fnd_d, b_fnd_q, b_fnd_d, found_q, found_d, rev_q, rev_d;
  logic [CW-1:0]  j_q, j_d;
  logic [WLP-1:0] head_q, head_d, tail_q, tail_d;
  logic [VCW-1:0] depth_q, depth_d, len_q, len_d, k_q, k_d;
  status_e        resp_q, resp_d;
  logic                out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [OLABEL_W-1:0] out_label_q, out_label_d;
  status_e             out_status_q, out_status_d;

  // Memories
  logic [LB-1:0] lbl_mem [MV];
  logic [LB-1:0] lbl_rd_q, lbl_wd;
  logic [VI-1:0] lbl_ra, lbl_wa;
  logic          lbl_re, lbl_we;
  logic [VI-1:0] nl_mem [NLD];
  logic [VI-1:0] nl_rd_q, nl_wd;
  logic [VI+DI-1:0] nl_ra, nl_wa;
  logic          nl_re, nl_we;
  logic [VI-1:0] wl_mem [WLD];
  logic [VI-1:0] wl_rd_q, wl_wd;
  logic [WLI-1:0] wl_ra, wl_wa;
  logic          wl_re, wl_we;

  always_ff @(posedge clk_i) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    if (lbl_re) lbl_rd_q <= lbl_mem[lbl_ra];
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
    if (nl_re) nl_rd_q <= nl_mem[nl_ra];
    if (wl_we) wl_mem[wl_wa] <= wl_wd;
    if (wl_re) wl_rd_q <= wl_mem[wl_ra];
  end

  logic           out_free, is_stack, is_rec;
  logic [VI-1:0]  pb_ra, pb_rd, cnt_ra;
  logic [CW-1:0]  cnt_rd, pos_rd;
  logic [VCW-1:0] dm1, pbi, elen;
  logic [WLP-1:0] tm1;

  assign out_free = !out_valid_q || res_m.ready;
  assign is_stack = (mode_q == MODE_STACK);
  assign is_rec   = (mode_q == MODE_REC);
  assign dm1      = depth_q - VCW'(1);
  assign tm1      = tail_q - WLP'(1);
  assign pbi      = rev_q ? (len_q - VCW'(1) - k_q) : k_q;
  assign elen     = (32'(len_q) > MAX_RESULTS) ? VCW'(MAX_RESULTS) : len_q;
  assign pb_ra    = (state_q == S_EMIT_RD) ? pbi[VI-1:0] : dm1[VI-1:0];
  assign pb_rd    = pb_q[pb_ra];
  assign pos_rd   = pos_q[dm1[VI-1:0]];

  always_comb begin
    unique case (state_q)
      S_REC_STEP:                        cnt_ra = pb_rd;
      S_EDGE_RD, S_EDGE_CHK, S_EDGE_FIN: cnt_ra = a_q;
      default:                           cnt_ra = cur_q;
    endcase
  end
  assign cnt_rd = ncount_q[cnt_ra];

  assign cmd_s.ready        = (state_q == S_IDLE);
  assign cfg_s.ready        = 1'b1;
  assign res_m.valid        = out_valid_q;
  assign res_m.vertex_label = out_label_q;
  assign res_m.status       = out_status_q;
  assign res_m.last         = out_last_q;

  always_comb begin
    state_d = state_q;   vcount_d = vcount_q; ncount_d = ncount_q;
    visited_d = visited_q; pred_v_d = pred_v_q; pred_d = pred_q;
    pb_d = pb_q;         pos_d = pos_q;       cmd_d = cmd_q;
    ka_d = ka_q;         kb_d = kb_q;         idx_d = idx_q;
    a_d = a_q;           b_d = b_q;           cur_d = cur_q;
    a_fnd_d = a_fnd_q;   b_fnd_d = b_fnd_q;   found_d = found_q;
    rev_d = rev_q;       j_d = j_q;           head_d = head_q;
    tail_d = tail_q;     depth_d = depth_q;   len_d = len_q;
    k_d = k_q;           resp_d = resp_q;
    out_valid_d = out_valid_q && !res_m.ready;
    out_label_d = out_label_q; out_status_d = out_status_q; out_last_d = out_last_q;
    lbl_re = 1'b0; lbl_ra = '0; lbl_we = 1'b0; lbl_wa = '0; lbl_wd = ka_q;
    nl_re = 1'b0;  nl_ra = '0;  nl_we = 1'b0;  nl_wa = '0;  nl_wd = b_q;
    wl_re = 1'b0;  wl_ra = '0;  wl_we = 1'b0;  wl_wa = '0;  wl_wd = a_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_s.valid) begin
          cmd_d = cmd_e'(cmd_s.cmd);
          ka_d  = LB'(cmd_s.key_a);
          kb_d  = LB'(cmd_s.key_b);
          idx_d = '0; a_fnd_d = 1'b0; b_fnd_d = 1'b0;
          unique case (cmd_e'(cmd_s.cmd))
            CMD_ADD_VERTEX: begin
              state_d = S_RESP;
              if (32'(vcount_q) >= MV) begin
                resp_d = STAT_VTX_FULL;
              end else begin
                resp_d = STAT_OK;
                lbl_we = 1'b1; lbl_wa = vcount_q[VI-1:0]; lbl_wd = LB'(cmd_s.key_a);
                // The self-loop is always the first edge of a new vertex.
                nl_we = 1'b1; nl_wa = {vcount_q[VI-1:0], DI'(0)}; nl_wd = vcount_q[VI-1:0];
                ncount_d[vcount_q[VI-1:0]] = CW'(1);
                vcount_d = vcount_q + VCW'(1);
              end
            end
            CMD_ADD_EDGE, CMD_FIND: state_d = S_LOOK_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LOOK_RD: begin
        if (idx_q >= vcount_q) begin
          if (!(a_fnd_q && b_fnd_q)) begin
            resp_d = STAT_UNKNOWN; state_d = S_RESP;
          end else if (cmd_q == CMD_ADD_EDGE) begin
            j_d = '0; found_d = 1'b0; state_d = S_EDGE_RD;
          end else begin
            visited_d = '0; pred_v_d = '0; k_d = '0;
            if (is_rec) begin
              pb_d[0] = a_q;
              if (a_q == b_q) begin
                len_d = VCW'(1); rev_d = 1'b0; state_d = S_EMIT_RD;
              end else begin
                pos_d[0] = '0; visited_d[a_q] = 1'b1;
                depth_d = VCW'(1); state_d = S_REC_STEP;
              end
            end else begin
              wl_we = 1'b1; wl_wa = '0; wl_wd = a_q;
              head_d = '0; tail_d = WLP'(1);
              if (!is_stack) visited_d[a_q] = 1'b1;
              state_d = S_WL_POP;
            end
          end
        end else begin
          lbl_re = 1'b1; lbl_ra = idx_q[VI-1:0]; state_d = S_LOOK_CMP;
        end
      end
      S_LOOK_CMP: begin
        // The lowest index wins, so later duplicates stay shadowed.
        if (!a_fnd_q && lbl_rd_q == ka_q) begin
          a_fnd_d = 1'b1; a_d = idx_q[VI-1:0];
        end
        if (!b_fnd_q && lbl_rd_q == kb_q) begin
          b_fnd_d = 1'b1; b_d = idx_q[VI-1:0];
        end
        idx_d = idx_q + VCW'(1);
        state_d = S_LOOK_RD;
      end
      S_EDGE_RD: begin
        if (j_q < cnt_rd) begin
          nl_re = 1'b1; nl_ra = {a_q, j_q[DI-1:0]}; state_d = S_EDGE_CHK;
        end else begin
          state_d = S_EDGE_FIN;
        end
      end
      S_EDGE_CHK: begin
        // Once the old edge is found, every later entry moves down by one.
        if (found_q) begin
          nl_we = 1'b1; nl_wa = {a_q, DI'(j_q - CW'(1))}; nl_wd = nl_rd_q;
        end else if (nl_rd_q == b_q) begin
          found_d = 1'b1;
        end
        j_d = j_q + CW'(1);
        state_d = S_EDGE_RD;
      end
      S_EDGE_FIN: begin
        state_d = S_RESP;
        resp_d  = STAT_OK;
        if (found_q) begin
          nl_we = 1'b1; nl_wa = {a_q, DI'(cnt_rd - CW'(1))};
        end else if (32'(cnt_rd) >= MD) begin
          resp_d = STAT_ADJ_FULL;
        end else begin
          nl_we = 1'b1; nl_wa = {a_q, cnt_rd[DI-1:0]};
          ncount_d[a_q] = cnt_rd + CW'(1);
        end
      end
      S_WL_POP: begin
        if (is_stack) begin
          if (tail_q != '0) begin
            wl_re = 1'b1; wl_ra = tm1[WLI-1:0]; tail_d = tm1; state_d = S_WL_CUR;
          end else begin
            resp_d = STAT_NO_PATH; state_d = S_RESP;
          end
        end else begin
          if (head_q < tail_q) begin
            wl_re = 1'b1; wl_ra = head_q[WLI-1:0];
            head_d = head_q + WLP'(1); state_d = S_WL_CUR;
          end else begin
            resp_d = STAT_NO_PATH; state_d = S_RESP;
          end
        end
      end
      S_WL_CUR: begin
        cur_d = wl_rd_q;
        if (wl_rd_q == b_q) begin
          len_d = '0; state_d = S_TRACE;
        end else if (is_stack && visited_q[wl_rd_q]) begin
          state_d = S_WL_POP;
        end else begin
          visited_d[wl_rd_q] = 1'b1; j_d = '0; state_d = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (j_q < cnt_rd) begin
          nl_re = 1'b1; nl_ra = {cur_q, j_q[DI-1:0]}; state_d = S_NB_CHK;
        end else begin
          state_d = S_WL_POP;
        end
      end
      S_NB_CHK: begin
        if (!visited_q[nl_rd_q] && tail_q < WLP'(WLD)) begin
          pred_d[nl_rd_q] = cur_q; pred_v_d[nl_rd_q] = 1'b1;
          wl_we = 1'b1; wl_wa = tail_q[WLI-1:0]; wl_wd = nl_rd_q;
          tail_d = tail_q + WLP'(1);
          if (!is_stack) visited_d[nl_rd_q] = 1'b1;
        end
        j_d = j_q + CW'(1);
        state_d = S_NB_RD;
      end
      S_TRACE: begin
        // The path is collected destination first and emitted in reverse.
        pb_d[len_q[VI-1:0]] = cur_q;
        len_d = len_q + VCW'(1);
        if (!pred_v_q[cur_q] || (32'(len_q) + 1 >= MV)) begin
          rev_d = 1'b1; k_d = '0; state_d = S_EMIT_RD;
        end else begin
          cur_d = pred_q[cur_q];
        end
      end
      S_REC_STEP: begin
        if (depth_q == '0) begin
          resp_d = STAT_NO_PATH; state_d = S_RESP;
        end else if (pos_rd < cnt_rd) begin
          pos_d[dm1[VI-1:0]] = pos_rd + CW'(1);
          nl_re = 1'b1; nl_ra = {pb_rd, pos_rd[DI-1:0]};
          state_d = S_REC_CHK;
        end else begin
          depth_d = dm1;
        end
      end
      S_REC_CHK: begin
        state_d = S_REC_STEP;
        if (!visited_q[nl_rd_q] && (32'(depth_q) < MV)) begin
          pb_d[depth_q[VI-1:0]] = nl_rd_q;
          if (nl_rd_q == b_q) begin
            len_d = depth_q + VCW'(1); rev_d = 1'b0; k_d = '0; state_d = S_EMIT_RD;
          end else begin
            visited_d[nl_rd_q] = 1'b1;
            pos_d[depth_q[VI-1:0]] = '0;
            depth_d = depth_q + VCW'(1);
          end
        end
      end
      S_EMIT_RD: begin
        lbl_re = 1'b1; lbl_ra = pb_rd; state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1; out_label_d = OLABEL_W'(lbl_rd_q);
          out_status_d = STAT_OK;
          out_last_d = (k_q + VCW'(1) == elen);
          k_d = k_q + VCW'(1);
          state_d = (k_q + VCW'(1) == elen) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1; out_label_d = '0;
          out_status_d = resp_q; out_last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_BFS;
      vcount_q <= '0;
      for (int i = 0; i < MV; i++) begin
        ncount_q[i] <= '0;
      end
      visited_q <= '0;
      pred_v_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_s.valid) mode_q <= cfg_s.data;
      vcount_q <= vcount_d;
      ncount_q <= ncount_d;
      visited_q <= visited_d;
      pred_v_q <= pred_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pred_q <= pred_d;   pb_q <= pb_d;       pos_q <= pos_d;
    cmd_q <= cmd_d;     ka_q <= ka_d;       kb_q <= kb_d;
    idx_q <= idx_d;     a_q <= a_d;         b_q <= b_d;
    cur_q <= cur_d;     a_fnd_q <= a_fnd_d; b_fnd_q <= b_fnd_d;
    found_q <= found_d; rev_q <= rev_d;     j_q <= j_d;
    head_q <= head_d;   tail_q <= tail_d;   depth_q <= depth_d;
    len_q <= len_d;     k_q <= k_d;         resp_q <= resp_d;
    out_label_q <= out_label_d; out_status_q <= out_status_d; out_last_q <= out_last_d;
  end

  a_vcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(vcount_q) <= MV) else $error("vertex count beyond table size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_m.ready) |=> (out_valid_q && $stable(out_label_q)
      && $stable(out_last_q)))
    else $error("waiting result overwritten");

  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_OUT) |-> (k_q < elen))
    else $error("emit index past path length");

  a_trace_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRACE) |-> (32'(len_q) < MV))
    else $error("trace longer than vertex table");

endmodule

[bench/graph_path_search_test.sv]
module graph_path_search_test;
  import gps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV        = MAX_VERTICES_DEF;
  localparam int ND        = MAX_DEGREE_DEF;
  localparam int WL_SIZE   = NV * ND + 1;
  localparam int SETTLE    = 800;
  localparam int MAX_CYCLE = 3000000;

  typedef struct packed {
    logic [OLABEL_W-1:0] label;
    logic [STATUS_W-1:0] status;
    logic                last;
  } path_result_t;

  logic clk_i;
  logic rst_ni;

  gps_cmd_if cmd_if ();
  gps_res_if res_if ();
  gps_cfg_if cfg_if ();

  graph_path_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_s  (cmd_if),
    .res_m  (res_if),
    .cfg_s  (cfg_if)
  );

  // Model of the graph held by the block.
  logic [KEY_W-1:0]  vtx_label [NV];
  int                vtx_count;
  int                nbr_list [NV][ND];
  int                nbr_count [NV];
  logic [MODE_W-1:0] mode_now;
  bit                seen [NV];
  int                came_from [NV];
  int                route [NV];

  path_result_t      pending_q[$];
  int                mismatches;
  int                cycles;
  bit                sender_burst;
  bit                receiver_burst;
  bit                long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > MAX_CYCLE) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int find_vertex(logic [KEY_W-1:0] key);
    for (int i = 0; i < vtx_count && i < NV; i++) begin
      if (vtx_label[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void push_result(logic [KEY_W-1:0] label, status_e st, logic lst);
    path_result_t r;
    r.label  = label;
    r.status = st;
    r.last   = lst;
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic int trace_route(int idx);
    int tmp [NV];
    int len;
    len = 0;
    while (len < NV) begin
      tmp[len] = idx;
      len++;
      if (came_from[idx] < 0) break;
      idx = came_from[idx];
    end
    for (int i = 0; i < len; i++) route[i] = tmp[len - 1 - i];
    return len;
  endfunction

  function automatic int search_breadth(int from, int to);
    int wl [WL_SIZE];
    int head, tail, cur, n;
    head = 0;
    tail = 0;
    wl[tail] = from;
    tail++;
    seen[from] = 1'b1;
    while (head < tail) begin
      cur = wl[head];
      head++;
      if (cur == to) return trace_route(cur);
      seen[cur] = 1'b1;
      for (int i = 0; i < nbr_count[cur] && i < ND; i++) begin
        n = nbr_list[cur][i];
        if (!seen[n] && tail < WL_SIZE) begin
          came_from[n] = cur;
          wl[tail] = n;
          tail++;
          seen[n] = 1'b1;
        end
      end
    end
    return 0;
  endfunction

  // A vertex counts as visited only when it is popped, so predecessors may be overwritten.
  function automatic int search_depth(int from, int to);
    int wl [WL_SIZE];
    int sp, cur, n;
    sp = 0;
    wl[sp] = from;
    sp++;
    while (sp > 0) begin
      sp--;
      cur = wl[sp];
      if (cur == to) return trace_route(cur);
      if (!seen[cur]) begin
        seen[cur] = 1'b1;
        for (int i = 0; i < nbr_count[cur] && i < ND; i++) begin
          n = nbr_list[cur][i];
          if (!seen[n] && sp < WL_SIZE) begin
            came_from[n] = cur;
            wl[sp] = n;
            sp++;
          end
        end
      end
    end
    return 0;
  endfunction

  function automatic int search_recursive(int from, int to);
    int pos [NV];
    int depth, v, c, i;
    route[0] = from;
    if (from == to) return 1;
    pos[0] = 0;
    seen[from] = 1'b1;
    depth = 1;
    while (depth > 0) begin
      v = route[depth - 1];
      i = pos[depth - 1];
      if (i < nbr_count[v] && i < ND) begin
        pos[depth - 1] = i + 1;
        c = nbr_list[v][i];
        if (!seen[c] && depth < NV) begin
          route[depth] = c;
          if (c == to) return depth + 1;
          seen[c] = 1'b1;
          pos[depth] = 0;
          depth++;
        end
      end else begin
        depth--;
      end
    end
    return 0;
  endfunction

  function automatic void model_command(cmd_e c, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
    int a, b, cnt, len;
    if (c == CMD_NONE) return;
    if (c == CMD_ADD_VERTEX) begin
      if (vtx_count >= NV) begin
        push_result('0, STAT_VTX_FULL, 1'b1);
      end else begin
        vtx_label[vtx_count] = ka;
        nbr_list[vtx_count][0] = vtx_count;
        nbr_count[vtx_count] = 1;
        vtx_count++;
        push_result('0, STAT_OK, 1'b1);
      end
      return;
    end
    a = find_vertex(ka);
    b = find_vertex(kb);
    if (a < 0 || b < 0) begin
      push_result('0, STAT_UNKNOWN, 1'b1);
      return;
    end
    if (c == CMD_ADD_EDGE) begin
      cnt = nbr_count[a];
      for (int i = 0; i < cnt; i++) begin
        if (nbr_list[a][i] == b) begin
          for (int j = i; j + 1 < cnt; j++) nbr_list[a][j] = nbr_list[a][j + 1];
          cnt--;
          break;
        end
      end
      if (cnt >= ND) begin
        push_result('0, STAT_ADJ_FULL, 1'b1);
      end else begin
        nbr_list[a][cnt] = b;
        nbr_count[a] = cnt + 1;
        push_result('0, STAT_OK, 1'b1);
      end
      return;
    end
    for (int i = 0; i < NV; i++) begin
      seen[i] = 1'b0;
      came_from[i] = -1;
    end
    if (mode_now == MODE_STACK) len = search_depth(a, b);
    else if (mode_now == MODE_REC) len = search_recursive(a, b);
    else len = search_breadth(a, b);
    if (len == 0) begin
      push_result('0, STAT_NO_PATH, 1'b1);
    end else begin
      if (len > MAX_RESULTS) len = MAX_RESULTS;
      for (int k = 0; k < len; k++) push_result(vtx_label[route[k]], STAT_OK, k + 1 == len);
    end
  endfunction

  // Checks every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    path_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: label %h status %0d last %0d",
                   res_if.vertex_label, res_if.status, res_if.last);
      end else begin
        want = pending_q.pop_front();
        if (res_if.vertex_label !== want.label || res_if.status !== want.status ||
            res_if.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected label %h status %0d last %0d, got %h %0d %0d",
                     want.label, want.status, want.last,
                     res_if.vertex_label, res_if.status, res_if.last);
        end
      end
    end
  end

  // Receiver: random stalls per result, with one long hold-off when asked.
  initial begin
    int n;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        n = 400;
        long_hold = 1'b0;
      end else begin
        n = receiver_burst ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic send_cmd(cmd_e c, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= c;
    cmd_if.key_a <= ka;
    cmd_if.key_b <= kb;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    model_command(c, ka, kb);
  endtask

  task automatic stop_sending();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Unused commands give no result, so the block is given time to settle as well.
  task automatic wait_idle();
    stop_sending();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [MODE_W-1:0] m);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    mode_now = m;
  endtask

  task automatic test_empty_graph();
    send_cmd(CMD_FIND, 32'h0, 32'h0);
    send_cmd(CMD_ADD_EDGE, 32'h1234_5678, 32'h0);
    send_cmd(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_build_graph();
    send_cmd(CMD_ADD_VERTEX, 32'h0, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD_VERTEX, 32'hFFFF_FFFF, 32'h0);
    send_cmd(CMD_ADD_VERTEX, 32'h5555_5555, 32'h0);
    send_cmd(CMD_ADD_VERTEX, 32'hAAAA_AAAA, 32'h0);
    // A second copy of a label is stored but never found by lookup.
    send_cmd(CMD_ADD_VERTEX, 32'hFFFF_FFFF, 32'h0);
    send_cmd(CMD_ADD_EDGE, 32'h0, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD_EDGE, 32'hFFFF_FFFF, 32'h5555_5555);
    send_cmd(CMD_ADD_EDGE, 32'h0, 32'h5555_5555);
    send_cmd(CMD_ADD_EDGE, 32'h0, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD_EDGE, 32'h0, 32'h0);
    send_cmd(CMD_ADD_EDGE, 32'hAAAA_AAAA, 32'h0);
  endtask

  task automatic test_search_modes();
    for (int m = 0; m < 4; m++) begin
      set_mode(m[MODE_W-1:0]);
      send_cmd(CMD_FIND, 32'hAAAA_AAAA, 32'h5555_5555);
      send_cmd(CMD_FIND, 32'h5555_5555, 32'h5555_5555);
      send_cmd(CMD_FIND, 32'h5555_5555, 32'h0);
      send_cmd(CMD_FIND, 32'h0, 32'h1357_9BDF);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_label();
    if (vtx_count == 0 || $urandom_range(0, 19) == 0) return $urandom;
    return vtx_label[$urandom_range(0, vtx_count - 1)];
  endfunction

  task automatic random_items(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) send_cmd(CMD_ADD_VERTEX, ($urandom_range(0, 7) == 0) ? pick_label() : $urandom,
                           $urandom);
      else if (r < 55) send_cmd(CMD_ADD_EDGE, pick_label(), pick_label());
      else if (r < 96) send_cmd(CMD_FIND, pick_label(), pick_label());
      else send_cmd(CMD_NONE, $urandom, $urandom);
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      set_mode(MODE_W'(p % 4));
      sender_burst   = (p == 2);
      receiver_burst = (p == 3 || p == 2);
      random_items(45);
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    sender_burst = 1'b1;
    random_items(12);
    sender_burst = 1'b0;
    // Let everything drain before sending on.
    stop_sending();
    while (pending_q.size() != 0) @(posedge clk_i);
    random_items(8);
  endtask

  task automatic test_vertex_full();
    while (vtx_count < NV) send_cmd(CMD_ADD_VERTEX, $urandom, $urandom);
    send_cmd(CMD_ADD_VERTEX, 32'h0BAD_F00D, 32'h0);
    send_cmd(CMD_ADD_VERTEX, 32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_long_path();
    for (int i = 0; i + 1 < NV; i++) send_cmd(CMD_ADD_EDGE, vtx_label[i], vtx_label[i + 1]);
    for (int i = 1; i < NV; i++) send_cmd(CMD_ADD_EDGE, vtx_label[0], vtx_label[i]);
    for (int m = 0; m < 3; m++) begin
      set_mode(m[MODE_W-1:0]);
      send_cmd(CMD_FIND, vtx_label[0], vtx_label[NV - 1]);
      send_cmd(CMD_FIND, vtx_label[NV - 1], vtx_label[0]);
    end
  endtask

  initial begin
    mismatches     = 0;
    vtx_count      = 0;
    mode_now       = MODE_BFS;
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    long_hold      = 1'b0;
    for (int i = 0; i < NV; i++) nbr_count[i] = 0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd   = CMD_ADD_VERTEX;
    cmd_if.key_a = '0;
    cmd_if.key_b = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_graph();
    test_build_graph();
    test_search_modes();
    test_random();
    test_backpressure();
    test_vertex_full();
    test_long_path();

    wait_idle();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
